// ----- design/segment_twinkle_engine_macros.svh -----
// ----------------------------------------------------------------------------
// segment_twinkle_engine_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_TWINKLE_ENGINE_MACROS_SVH
`define SEGMENT_TWINKLE_ENGINE_MACROS_SVH

// antecedent and consequent in the same cycle
`define STE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent
`define STE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ste_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_pkg
// Shared constants, types and functions of the segment twinkle engine.
// ----------------------------------------------------------------------------
package ste_pkg;

    localparam int MAX_SEGMENTS = 96;
    localparam int SEG_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int CFG_W        = 7;
    localparam int NUM_WORDS    = (MAX_SEGMENTS + 31) / 32;
    localparam int LIT_W        = NUM_WORDS * 32;
    localparam int WIDX_W       = 2;

    // remainder unit: bits retired per cycle and steps per item
    localparam int DIV_BITS     = 4;
    localparam int DIV_STEPS    = 32 / DIV_BITS;
    localparam int DIV_STEP_W   = $clog2(DIV_STEPS);

    localparam logic [CFG_W-1:0] SEG_COUNT_RESET = 7'd64;
    localparam logic [4:0]       PREV_HOUR_RESET = 5'd31;

    localparam logic [31:0] RESTART_XOR  = 32'hA5A5A5A5;
    localparam logic [31:0] RESTART_MUL  = 32'd1664525;
    localparam logic [31:0] RESTART_ADD  = 32'd1013904223;
    localparam logic [31:0] HOUR_XOR     = 32'hC3C3C3C3;
    localparam logic [31:0] HOUR_MUL     = 32'd1103515245;
    localparam logic [31:0] HOUR_ADD     = 32'd12345;

    typedef struct packed {
        logic [1:0] rate;
        logic [1:0] phase;
        logic       inv;
    } t_attr;

    typedef struct packed {
        logic             we;
        logic [SEG_W-1:0] addr;
        logic [SEG_W-1:0] data;
    } t_ord_wr;

    typedef struct packed {
        logic             we;
        logic [SEG_W-1:0] addr;
        t_attr            data;
    } t_attr_wr;

    function automatic logic [31:0] xorshift32(input logic [31:0] s);
        logic [31:0] x;
        x = s ^ (s << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

    function automatic logic blink_on(input t_attr a, input logic [1:0] sub);
        logic [1:0] t;
        logic       on;
        t = sub + a.phase;
        unique case (a.rate)
            2'd0:    on = (t == 2'd0);
            2'd2:    on = (t != 2'd3);
            default: on = !t[0];
        endcase
        return on ^ a.inv;
    endfunction

endpackage

// ----- design/ste_mod_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_mod_unit
// Iterative remainder of a 32-bit word by a small divisor, DIV_BITS per cycle.
// ----------------------------------------------------------------------------
module ste_mod_unit import ste_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [31:0]      i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [CNT_W-1:0] o_rem
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_step;
    logic [31:0]           r_num;
    logic [CNT_W-1:0]      r_rem;
    logic [CNT_W-1:0]      r_div;

    logic [31:0]      n_num;
    logic [CNT_W-1:0] n_rem;
    logic [CNT_W:0]   t;

    always_comb begin
        n_num = r_num;
        n_rem = r_rem;
        t     = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            t     = {n_rem, n_num[31]};
            n_num = {n_num[30:0], 1'b0};
            if (t >= {1'b0, r_div}) begin
                t = t - {1'b0, r_div};
            end
            n_rem = t[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_num  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_num  <= n_num;
                r_rem  <= n_rem;
                r_step <= r_step + 1'b1;
                if (r_step == DIV_STEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- design/ste_order_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_order_mem
// Shuffled segment order: one write port, two registered read ports.
// Entries not written since the last clear read as their own address.
// ----------------------------------------------------------------------------
module ste_order_mem import ste_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clr,
    input  t_ord_wr          i_wr,
    input  logic [SEG_W-1:0] i_raddr_a,
    input  logic [SEG_W-1:0] i_raddr_b,
    output logic [SEG_W-1:0] o_rdata_a,
    output logic [SEG_W-1:0] o_rdata_b
);

    logic [SEG_W-1:0]        mem [MAX_SEGMENTS];
    logic [MAX_SEGMENTS-1:0] r_vld;
    logic [SEG_W-1:0]        r_q_a, r_q_b;
    logic [SEG_W-1:0]        r_addr_a, r_addr_b;
    logic                    r_hit_a, r_hit_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_q_a    <= mem[i_raddr_a];
        r_q_b    <= mem[i_raddr_b];
        r_addr_a <= i_raddr_a;
        r_addr_b <= i_raddr_b;
        r_hit_a  <= r_vld[i_raddr_a];
        r_hit_b  <= r_vld[i_raddr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_clr) begin
            r_vld <= '0;
        end else if (i_wr.we) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    assign o_rdata_a = r_hit_a ? r_q_a : r_addr_a;
    assign o_rdata_b = r_hit_b ? r_q_b : r_addr_b;

endmodule

// ----- design/ste_attr_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_attr_mem
// Per-segment blink rate, phase and invert flag; unwritten entries read zero.
// ----------------------------------------------------------------------------
module ste_attr_mem import ste_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_attr_wr         i_wr,
    input  logic [SEG_W-1:0] i_raddr,
    output t_attr            o_rdata
);

    t_attr                   mem [MAX_SEGMENTS];
    logic [MAX_SEGMENTS-1:0] r_vld;
    t_attr                   r_q;
    logic                    r_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_q   <= mem[i_raddr];
        r_hit <= r_vld[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.we) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    assign o_rdata = r_hit ? r_q : '0;

endmodule

// ----- design/segment_twinkle_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_twinkle_engine
// Twinkles display segments on each tick item; emits the lit bitmap as words.
// ----------------------------------------------------------------------------
// Plain tick: renders min(N, active) positions, then NUM_WORDS result words.
// Reshuffle tick adds N-1 swaps and an attribute pass: each swap waits on the
// remainder unit (8 steps plus done) plus the read/write turn of the order memory.
// One item at a time; the next item is taken after the last word leaves.
// Synchronous active-low reset; no clearing pass, memories use valid bits.
// ----------------------------------------------------------------------------
module segment_twinkle_engine import ste_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_restart,
    input  logic [31:0]       i_rtc_word,
    input  logic [4:0]        i_hour,
    input  logic [5:0]        i_minute,
    input  logic [5:0]        i_second,
    input  logic [1:0]        i_subsecond,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [WIDX_W-1:0] o_word_index,
    output logic [31:0]       o_on_mask,
    output logic              o_last
);

    typedef enum logic [3:0] {
        S_IDLE, S_SEED, S_SHUF, S_DIV, S_RD, S_WR1, S_WR2,
        S_ATTR, S_REND0, S_REND, S_OUT
    } t_state;

    t_state            r_state;
    logic [CFG_W-1:0]  r_cfg;
    logic [31:0]       r_rng;
    logic [4:0]        r_prev_hour;
    logic              r_restart;
    logic [31:0]       r_rtc;
    logic [4:0]        r_hour;
    logic [5:0]        r_minute;
    logic [5:0]        r_second;
    logic [1:0]        r_sub;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_base;
    logic [2:0]        r_rem6;
    logic [CNT_W-1:0]  r_i;
    logic [CNT_W-1:0]  r_j;
    logic [SEG_W-1:0]  r_di;
    logic [CNT_W-1:0]  r_a;
    logic [1:0]        r_k;
    logic [1:0]        r_rate;
    logic [1:0]        r_phase;
    logic [CNT_W-1:0]  r_p;
    logic [CNT_W-1:0]  r_lim;
    logic              r_s1, r_s2;
    logic [SEG_W-1:0]  r_seg2;
    logic [LIT_W-1:0]  r_lit;
    logic [WIDX_W-1:0] r_w;

    logic [CNT_W-1:0]  n_used;
    logic [CNT_W+5:0]  base_prod;
    logic [CNT_W-1:0]  base_q;
    logic [CNT_W-1:0]  rem_q;
    logic [31:0]       seed;
    logic              reseed;
    logic [31:0]       rng_x;
    logic [2:0]        chunk1;
    logic [CNT_W+3:0]  target;
    logic [CNT_W-1:0]  lim;
    logic [CNT_W-1:0]  im1;
    logic              div_start, div_done;
    logic [CNT_W-1:0]  div_rem;
    logic              ord_clr;
    t_ord_wr           ord_wr;
    logic [SEG_W-1:0]  ord_ra, ord_rb, ord_qa, ord_qb;
    t_attr_wr          attr_wr;
    t_attr             attr_q;

    always_comb begin
        if (int'(r_cfg) > MAX_SEGMENTS) begin
            n_used = CNT_W'(MAX_SEGMENTS);
        end else begin
            n_used = CNT_W'(r_cfg);
        end
        // n / 6 by reciprocal, exact for n up to 128
        base_prod = (CNT_W+6)'(n_used) * (CNT_W+6)'(43);
        base_q    = base_prod[CNT_W+5:8] > 0 ? CNT_W'(base_prod >> 8) : '0;
        rem_q     = n_used - CNT_W'(base_q * CNT_W'(6));

        reseed = r_restart || (r_hour != r_prev_hour);
        if (r_restart) begin
            seed = (r_rtc ^ RESTART_XOR) + (32'(r_second) * RESTART_MUL + RESTART_ADD);
        end else begin
            seed = (r_rtc ^ HOUR_XOR) + (32'(r_second) * HOUR_MUL + HOUR_ADD);
        end
        rng_x = xorshift32(r_rng);

        // chunk index plus one, saturating at six
        priority if (r_minute >= 6'd50) chunk1 = 3'd6;
        else if (r_minute >= 6'd40)     chunk1 = 3'd5;
        else if (r_minute >= 6'd30)     chunk1 = 3'd4;
        else if (r_minute >= 6'd20)     chunk1 = 3'd3;
        else if (r_minute >= 6'd10)     chunk1 = 3'd2;
        else                            chunk1 = 3'd1;
        target = (CNT_W+4)'(chunk1) * (CNT_W+4)'(r_base)
               + (CNT_W+4)'((chunk1 < r_rem6) ? chunk1 : r_rem6);
        if (target > (CNT_W+4)'(n_used)) begin
            lim = n_used;
        end else begin
            lim = CNT_W'(target);
        end

        im1       = r_i - 1'b1;
        div_start = (r_state == S_SHUF) && (r_i > CNT_W'(1));
        ord_clr   = (r_state == S_SEED) && reseed;
        ord_ra    = (r_state == S_RD) ? im1[SEG_W-1:0] : r_p[SEG_W-1:0];
        ord_rb    = r_j[SEG_W-1:0];

        ord_wr.we   = (r_state == S_WR1) || (r_state == S_WR2);
        ord_wr.addr = (r_state == S_WR1) ? im1[SEG_W-1:0] : r_j[SEG_W-1:0];
        ord_wr.data = (r_state == S_WR1) ? ord_qb : r_di;

        attr_wr.we         = (r_state == S_ATTR) && (r_a < r_n) && (r_k == 2'd2);
        attr_wr.addr       = r_a[SEG_W-1:0];
        attr_wr.data.rate  = r_rate;
        attr_wr.data.phase = r_phase;
        attr_wr.data.inv   = rng_x[0];
    end

    ste_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (rng_x),
        .i_divisor  (r_i),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    ste_order_mem u_order (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (ord_clr),
        .i_wr      (ord_wr),
        .i_raddr_a (ord_ra),
        .i_raddr_b (ord_rb),
        .o_rdata_a (ord_qa),
        .o_rdata_b (ord_qb)
    );

    ste_attr_mem u_attr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (attr_wr),
        .i_raddr (ord_qa),
        .o_rdata (attr_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= SEG_COUNT_RESET;
            r_rng       <= '0;
            r_prev_hour <= PREV_HOUR_RESET;
            r_base      <= '0;
            r_rem6      <= '0;
            r_s1        <= 1'b0;
            r_s2        <= 1'b0;
            r_w         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            // render pipeline: order read, then attribute read, then lit bit
            r_s1   <= (r_state == S_REND) && (r_p < r_lim);
            r_s2   <= r_s1;
            r_seg2 <= ord_qa;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_restart <= i_restart;
                        r_rtc     <= i_rtc_word;
                        r_hour    <= i_hour;
                        r_minute  <= i_minute;
                        r_second  <= i_second;
                        r_sub     <= i_subsecond;
                        r_state   <= S_SEED;
                    end
                end
                S_SEED: begin
                    if (reseed) begin
                        r_rng       <= seed;
                        r_prev_hour <= r_hour;
                        r_n         <= n_used;
                        r_i         <= n_used;
                        r_a         <= '0;
                        r_k         <= '0;
                        r_base      <= base_q;
                        r_rem6      <= rem_q[2:0];
                        r_state     <= S_SHUF;
                    end else begin
                        r_state <= S_REND0;
                    end
                end
                S_SHUF: begin
                    if (r_i > CNT_W'(1)) begin
                        r_rng   <= rng_x;
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_ATTR;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_j     <= div_rem;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_WR1;
                end
                S_WR1: begin
                    r_di    <= ord_qa;
                    r_state <= S_WR2;
                end
                S_WR2: begin
                    r_i     <= im1;
                    r_state <= S_SHUF;
                end
                S_ATTR: begin
                    if (r_a >= r_n) begin
                        r_state <= S_REND0;
                    end else begin
                        r_rng <= rng_x;
                        unique case (r_k)
                            2'd0: begin
                                r_rate <= rng_x[1:0];
                                r_k    <= 2'd1;
                            end
                            2'd1: begin
                                r_phase <= rng_x[1:0];
                                r_k     <= 2'd2;
                            end
                            default: begin
                                r_k <= 2'd0;
                                r_a <= r_a + 1'b1;
                            end
                        endcase
                    end
                end
                S_REND0: begin
                    r_lit   <= '0;
                    r_p     <= '0;
                    r_lim   <= lim;
                    r_state <= S_REND;
                end
                S_REND: begin
                    if (r_p < r_lim) begin
                        r_p <= r_p + 1'b1;
                    end
                    if (r_s2 && blink_on(attr_q, r_sub)) begin
                        r_lit[r_seg2] <= 1'b1;
                    end
                    if (!(r_p < r_lim) && !r_s1 && !r_s2) begin
                        r_w     <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        if (r_w == WIDX_W'(NUM_WORDS - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_w <= r_w + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = (r_state == S_OUT);
    assign o_word_index = r_w;
    assign o_on_mask    = r_lit[{r_w, 5'b0} +: 32];
    assign o_last       = (r_w == WIDX_W'(NUM_WORDS - 1));

endmodule

// ----- design/ste_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ste_checker
// Port-level checks of the segment twinkle engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "segment_twinkle_engine_macros.svh"

module ste_checker import ste_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cfg_we,
    input logic [CFG_W-1:0]  i_cfg_wdata,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              i_restart,
    input logic [31:0]       i_rtc_word,
    input logic [4:0]        i_hour,
    input logic [5:0]        i_minute,
    input logic [5:0]        i_second,
    input logic [1:0]        i_subsecond,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [WIDX_W-1:0] o_word_index,
    input logic [31:0]       o_on_mask,
    input logic              o_last
);

    `STE_ASSERT_NEXT(a_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_on_mask) && $stable(o_word_index), "stalled item changed")
    `STE_ASSERT_SAME(a_excl, o_out_valid, !o_in_ready, "input taken while words pending")
    `STE_ASSERT_NEXT(a_step, o_out_valid && i_out_ready && !o_last, o_out_valid && o_word_index == $past(o_word_index) + 2'd1, "word index skipped")
    `STE_ASSERT_NEXT(a_end, o_out_valid && i_out_ready && o_last, !o_out_valid && o_in_ready, "extra word after last")

endmodule

bind segment_twinkle_engine ste_checker u_ste_checker (.*);

// ----- bench/tb_segment_twinkle_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_twinkle_engine
// Drives quarter-second tick items into the twinkle engine across several
// segment counts, predicts the lit bitmap words per tick and checks every
// word against the prediction in order.
// ----------------------------------------------------------------------------
module tb_segment_twinkle_engine;
    import ste_pkg::*;

    typedef struct {
        logic        restart;
        logic [31:0] rtc;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [1:0]  sub;
    } t_tick;

    typedef struct {
        logic [WIDX_W-1:0] widx;
        logic [31:0]       mask;
        logic              last;
    } t_word;

    class twinkle_scoreboard;
        logic [CFG_W-1:0] seg_count;
        logic [31:0]      rng;
        logic [4:0]       prev_hour;
        int               order[MAX_SEGMENTS];
        logic [1:0]       rate[MAX_SEGMENTS];
        logic [1:0]       phase[MAX_SEGMENTS];
        logic             inv[MAX_SEGMENTS];
        logic             lit[MAX_SEGMENTS];
        logic [6:0]       cum_active[6];
        t_word            pending_words[$];
        int               errors;

        function new();
            seg_count = SEG_COUNT_RESET;
            rng = '0;
            prev_hour = PREV_HOUR_RESET;
            for (int i = 0; i < MAX_SEGMENTS; i++) begin
                order[i] = i;
                rate[i] = '0;
                phase[i] = '0;
                inv[i] = 1'b0;
                lit[i] = 1'b0;
            end
            for (int i = 0; i < 6; i++) cum_active[i] = '0;
            errors = 0;
        endfunction

        function int used_count();
            return (seg_count > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(seg_count);
        endfunction

        function logic [31:0] step_rng();
            logic [31:0] x;
            x = rng;
            x = x ^ (x << 13);
            x = x ^ (x >> 17);
            x = x ^ (x << 5);
            rng = x;
            return x;
        endfunction

        function void reshuffle(logic [31:0] seed);
            int n, j, tmp, base, rem, sum;
            n = used_count();
            sum = 0;
            rng = seed;
            for (int i = 0; i < MAX_SEGMENTS; i++) order[i] = i;
            for (int i = n; i > 1; i--) begin
                j = int'(step_rng() % i);
                tmp = order[i-1];
                order[i-1] = order[j];
                order[j] = tmp;
            end
            for (int i = 0; i < n; i++) begin
                rate[i]  = 2'(step_rng() % 4);
                phase[i] = 2'(step_rng() & 3);
                inv[i]   = 1'(step_rng() & 1);
            end
            base = n / 6;
            rem = n % 6;
            for (int i = 0; i < 6; i++) begin
                sum += base + ((i < rem) ? 1 : 0);
                cum_active[i] = sum[6:0];
            end
            for (int i = 0; i < MAX_SEGMENTS; i++) lit[i] = 1'b0;
        endfunction

        // attributes are looked up by segment number, not by position
        function logic seg_on(int seg, logic [1:0] sub);
            int r, t;
            logic on;
            r = int'(rate[seg]) + 1;
            t = int'(sub) + int'(phase[seg]);
            if (r == 4 || r == 2) on = (t % 2) == 0;
            else if (r == 3)      on = (t % 4) != 3;
            else                  on = (t % 4) == 0;
            return on ^ inv[seg];
        endfunction

        function void note_tick(t_tick tk);
            int n, chunk, target, seg;
            t_word w;
            if (tk.restart) begin
                reshuffle((tk.rtc ^ RESTART_XOR) + (32'(tk.second) * RESTART_MUL + RESTART_ADD));
                prev_hour = tk.hour;
            end
            if (tk.hour != prev_hour) begin
                reshuffle((tk.rtc ^ HOUR_XOR) + (32'(tk.second) * HOUR_MUL + HOUR_ADD));
                prev_hour = tk.hour;
            end
            n = used_count();
            chunk = int'(tk.minute) / 10;
            if (chunk > 5) chunk = 5;
            target = int'(cum_active[chunk]);
            for (int idx = 0; idx < MAX_SEGMENTS; idx++) begin
                seg = order[idx] % MAX_SEGMENTS;
                lit[seg] = (idx < n && idx < target) ? seg_on(seg, tk.sub) : 1'b0;
            end
            for (int wi = 0; wi < NUM_WORDS; wi++) begin
                w.widx = WIDX_W'(wi);
                w.mask = '0;
                for (int b = 0; b < 32; b++)
                    if (wi * 32 + b < MAX_SEGMENTS && lit[wi*32+b]) w.mask[b] = 1'b1;
                w.last = (wi + 1 == NUM_WORDS);
                pending_words.push_back(w);
            end
        endfunction

        function void check_word(logic [WIDX_W-1:0] widx, logic [31:0] mask, logic last);
            t_word e;
            if (pending_words.size() == 0) begin
                $error("unexpected word: word_index %0d on_mask %h", widx, mask);
                errors++;
                return;
            end
            e = pending_words.pop_front();
            if (widx !== e.widx) begin
                $error("word_index: expected %0d, got %0d", e.widx, widx);
                errors++;
            end
            if (mask !== e.mask) begin
                $error("on_mask: expected %h, got %h", e.mask, mask);
                errors++;
            end
            if (last !== e.last) begin
                $error("last: expected %0d, got %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wdata = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic              i_restart = 1'b0;
    logic [31:0]       i_rtc_word = '0;
    logic [4:0]        i_hour = '0;
    logic [5:0]        i_minute = '0;
    logic [5:0]        i_second = '0;
    logic [1:0]        i_subsecond = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b1;
    logic [WIDX_W-1:0] o_word_index;
    logic [31:0]       o_on_mask;
    logic              o_last;

    twinkle_scoreboard sb = new();
    bit    quiet = 0;
    bit    hold_req = 0;
    int    idle_cycles = 0;
    t_tick clk_now;

    localparam int WATCHDOG_LIMIT = 40000;

    segment_twinkle_engine uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_restart    (i_restart),
        .i_rtc_word   (i_rtc_word),
        .i_hour       (i_hour),
        .i_minute     (i_minute),
        .i_second     (i_second),
        .i_subsecond  (i_subsecond),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_word_index (o_word_index),
        .o_on_mask    (o_on_mask),
        .o_last       (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_tick tk;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                tk.restart = i_restart;
                tk.rtc = i_rtc_word;
                tk.hour = i_hour;
                tk.minute = i_minute;
                tk.second = i_second;
                tk.sub = i_subsecond;
                sb.note_tick(tk);
            end
            if (o_out_valid && i_out_ready)
                sb.check_word(o_word_index, o_on_mask, o_last);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_segment_twinkle_engine: errors");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (3000) @(negedge i_clk);
                hold_req = 0;
                i_out_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send_tick(t_tick tk);
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_restart   <= tk.restart;
        i_rtc_word  <= tk.rtc;
        i_hour      <= tk.hour;
        i_minute    <= tk.minute;
        i_second    <= tk.second;
        i_subsecond <= tk.sub;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_count(logic [CFG_W-1:0] val);
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val;
        sb.seg_count = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_fields(bit rs, logic [31:0] rtc, logic [4:0] hr, logic [5:0] mn,
                               logic [5:0] sc, logic [1:0] ss);
        t_tick tk;
        tk.restart = rs;
        tk.rtc = rtc;
        tk.hour = hr;
        tk.minute = mn;
        tk.second = sc;
        tk.sub = ss;
        clk_now = tk;
        send_tick(tk);
    endtask

    // mostly a running clock; sometimes restarts, hour jumps, minute jumps or junk fields
    task automatic random_ticks(int count);
        t_tick tk;
        int r;
        for (int k = 0; k < count; k++) begin
            tk = clk_now;
            tk.restart = 1'b0;
            tk.rtc = $urandom;
            r = $urandom_range(0, 99);
            if (r < 4) begin
                tk.restart = 1'b1;
                tk.second = 6'($urandom_range(0, 63));
            end else if (r < 9) begin
                tk.hour = 5'($urandom_range(0, 23));
                tk.second = 6'($urandom_range(0, 63));
            end else if (r < 12) begin
                tk.hour = 5'($urandom_range(0, 31));
                tk.minute = 6'($urandom_range(0, 63));
                tk.second = 6'($urandom_range(0, 63));
                tk.sub = 2'($urandom_range(0, 3));
            end else if (r < 22) begin
                tk.minute = 6'($urandom_range(0, 59));
            end else begin
                tk.sub = tk.sub + 2'd1;
                if (tk.sub == 2'd0) begin
                    tk.second = (tk.second >= 6'd59) ? 6'd0 : tk.second + 6'd1;
                    if (tk.second == 6'd0)
                        tk.minute = (tk.minute >= 6'd59) ? 6'd0 : tk.minute + 6'd1;
                end
            end
            clk_now = tk;
            send_tick(tk);
        end
    endtask

    initial begin
        logic [CFG_W-1:0] counts[9];
        counts = '{7'd64, 7'd1, 7'd96, 7'd127, 7'd0, 7'd2, 7'd37, 7'd95, 7'd6};
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // first tick at hour 31 leaves the reset state in place
        send_fields(0, 32'h0, 5'd31, 6'd0, 6'd0, 2'd0);
        send_fields(0, 32'hFFFF_FFFF, 5'd0, 6'd0, 6'd0, 2'd1);
        send_fields(1, 32'h0, 5'd0, 6'd59, 6'd0, 2'd2);
        send_fields(1, 32'hFFFF_FFFF, 5'd23, 6'd63, 6'd63, 2'd3);
        for (int s = 0; s < 4; s++) send_fields(0, 32'h1234_5678, 5'd23, 6'd50, 6'd10, 2'(s));
        for (int m = 0; m < 6; m++) send_fields(0, 32'h0, 5'd16, 6'(m * 10), 6'd33, 2'd0);
        send_fields(0, 32'hDEAD_BEEF, 5'd5, 6'd9, 6'd59, 2'd3);
        send_fields(1, 32'h8000_0001, 5'd5, 6'd19, 6'd32, 2'd1);

        for (int p = 0; p < 9; p++) begin
            write_count(counts[p]);
            if (p == 1) hold_req = 1;
            if (p == 8) quiet = 1;
            random_ticks(53);
        end

        drain();
        if (sb.errors == 0)
            $display("tb_segment_twinkle_engine: clean");
        else
            $display("tb_segment_twinkle_engine: errors");
        $finish;
    end

endmodule
